// File: design/ude_pkg.sv
package ude_pkg;

	localparam int CORDIC_MAX = 30;
	localparam int ANGLE_W = 32;
	localparam int CORDIC_W = 32;
	localparam int TRIG_W = 16;
	localparam int TRIG_FRAC = 14;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd163008219;
	localparam logic signed [CORDIC_W-1:0] TRIG_RND = 32'sd8192;
	localparam logic signed [CORDIC_W-1:0] TRIG_HI = 32'sd16384;
	localparam logic signed [CORDIC_W-1:0] TRIG_LO = -32'sd16384;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

	localparam logic signed [CORDIC_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
		32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
		32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
		32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41,
		32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
	};

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		logic flip;
	} cordic_t;

	function automatic logic signed [TRIG_W-1:0] trig_round(
		input logic signed [CORDIC_W-1:0] v,
		input logic flip
	);
		logic signed [CORDIC_W-1:0] r;
		logic signed [TRIG_W-1:0] c;
		r = (v + TRIG_RND) >>> TRIG_FRAC;
		if (r > TRIG_HI) begin
			c = TRIG_ONE;
		end else if (r < TRIG_LO) begin
			c = -TRIG_ONE;
		end else begin
			c = r[TRIG_W-1:0];
		end
		return flip ? -c : c;
	endfunction

endpackage

// File: design/ude_if.sv
interface ude_in_if #(
	parameter int DATA_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] heading;
	logic signed [DATA_WIDTH-1:0] speed;
	logic signed [DATA_WIDTH-1:0] turn_rate;
	logic signed [DATA_WIDTH-1:0] accel;
	logic signed [DATA_WIDTH-1:0] turn_accel;

	modport source (
		output valid, heading, speed, turn_rate, accel, turn_accel,
		input ready
	);
	modport sink (
		input valid, heading, speed, turn_rate, accel, turn_accel,
		output ready
	);
endinterface

interface ude_out_if #(
	parameter int DATA_WIDTH = 16
);
	import ude_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] x_rate;
	logic signed [DATA_WIDTH-1:0] y_rate;
	logic signed [DATA_WIDTH-1:0] heading_rate;
	logic signed [DATA_WIDTH-1:0] speed_rate;
	logic signed [DATA_WIDTH-1:0] turn_rate_change;
	logic signed [DATA_WIDTH-1:0] jac_x_heading;
	logic signed [DATA_WIDTH-1:0] jac_y_heading;
	logic signed [TRIG_W-1:0] cos_heading;
	logic signed [TRIG_W-1:0] sin_heading;

	modport source (
		output valid, x_rate, y_rate, heading_rate, speed_rate, turn_rate_change,
		output jac_x_heading, jac_y_heading, cos_heading, sin_heading,
		input ready
	);
	modport sink (
		input valid, x_rate, y_rate, heading_rate, speed_rate, turn_rate_change,
		input jac_x_heading, jac_y_heading, cos_heading, sin_heading,
		output ready
	);
endinterface

// File: design/ude_cordic_step.sv
module ude_cordic_step #(
	parameter int STEP = 0,
	parameter int SIDE_W = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ude_pkg::cordic_t in_data,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	input  logic out_ready,
	output ude_pkg::cordic_t out_data,
	output logic [SIDE_W-1:0] out_side
);
	import ude_pkg::*;

	logic valid_s1;
	cordic_t cord_s1;
	logic [SIDE_W-1:0] side_s1;
	cordic_t cord_next;
	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;

	always_comb begin
		dx = in_data.y >>> STEP;
		dy = in_data.x >>> STEP;
		cord_next.flip = in_data.flip;
		if (!in_data.z[CORDIC_W-1]) begin
			cord_next.x = in_data.x - dx;
			cord_next.y = in_data.y + dy;
			cord_next.z = in_data.z - ATAN_TAB[STEP];
		end else begin
			cord_next.x = in_data.x + dx;
			cord_next.y = in_data.y - dy;
			cord_next.z = in_data.z + ATAN_TAB[STEP];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cord_s1 <= cord_next;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = cord_s1;
	assign out_side = side_s1;
endmodule

// File: design/ude_product.sv
module ude_product #(
	parameter int DATA_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [ude_pkg::TRIG_W-1:0] cos_in,
	input  logic signed [ude_pkg::TRIG_W-1:0] sin_in,
	input  logic signed [DATA_WIDTH-1:0] speed,
	input  logic signed [DATA_WIDTH-1:0] turn_rate,
	input  logic signed [DATA_WIDTH-1:0] accel,
	input  logic signed [DATA_WIDTH-1:0] turn_accel,
	ude_out_if.source result
);
	import ude_pkg::*;

	localparam int PW = DATA_WIDTH + TRIG_W;
	localparam int NW = PW + 1;
	localparam logic signed [NW-1:0] PROD_RND = NW'(1 << (TRIG_FRAC - 1));

	function automatic logic signed [DATA_WIDTH-1:0] round_sat(input logic signed [NW-1:0] p);
		logic signed [NW-1:0] r;
		logic [NW-DATA_WIDTH:0] top;
		logic signed [DATA_WIDTH-1:0] v;
		r = (p + PROD_RND) >>> TRIG_FRAC;
		top = r[NW-1:DATA_WIDTH-1];
		if (top == '0 || top == '1) begin
			v = r[DATA_WIDTH-1:0];
		end else if (r[NW-1]) begin
			v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end
		return v;
	endfunction

	logic valid_s1;
	logic ready_s1;
	logic signed [PW-1:0] pc_s1;
	logic signed [PW-1:0] ps_s1;
	logic signed [TRIG_W-1:0] cos_s1;
	logic signed [TRIG_W-1:0] sin_s1;
	logic signed [DATA_WIDTH-1:0] turn_rate_s1;
	logic signed [DATA_WIDTH-1:0] accel_s1;
	logic signed [DATA_WIDTH-1:0] turn_accel_s1;

	logic valid_s2;
	logic signed [DATA_WIDTH-1:0] xr_s2;
	logic signed [DATA_WIDTH-1:0] yr_s2;
	logic signed [DATA_WIDTH-1:0] jx_s2;
	logic signed [TRIG_W-1:0] cos_s2;
	logic signed [TRIG_W-1:0] sin_s2;
	logic signed [DATA_WIDTH-1:0] turn_rate_s2;
	logic signed [DATA_WIDTH-1:0] accel_s2;
	logic signed [DATA_WIDTH-1:0] turn_accel_s2;

	logic signed [PW-1:0] prod_c;
	logic signed [PW-1:0] prod_s;
	logic signed [NW-1:0] ext_c;
	logic signed [NW-1:0] ext_s;

	assign prod_c = speed * cos_in;
	assign prod_s = speed * sin_in;
	assign ext_c = NW'(pc_s1);
	assign ext_s = NW'(ps_s1);

	assign ready_s1 = !valid_s2 || result.ready;
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pc_s1 <= prod_c;
			ps_s1 <= prod_s;
			cos_s1 <= cos_in;
			sin_s1 <= sin_in;
			turn_rate_s1 <= turn_rate;
			accel_s1 <= accel;
			turn_accel_s1 <= turn_accel;
		end
		if (ready_s1 && valid_s1) begin
			xr_s2 <= round_sat(ext_c);
			yr_s2 <= round_sat(ext_s);
			jx_s2 <= round_sat(-ext_s);
			cos_s2 <= cos_s1;
			sin_s2 <= sin_s1;
			turn_rate_s2 <= turn_rate_s1;
			accel_s2 <= accel_s1;
			turn_accel_s2 <= turn_accel_s1;
		end
	end

	assign result.valid = valid_s2;
	assign result.x_rate = xr_s2;
	assign result.y_rate = yr_s2;
	assign result.heading_rate = turn_rate_s2;
	assign result.speed_rate = accel_s2;
	assign result.turn_rate_change = turn_accel_s2;
	assign result.jac_x_heading = jx_s2;
	assign result.jac_y_heading = xr_s2;
	assign result.cos_heading = cos_s2;
	assign result.sin_heading = sin_s2;
endmodule

// File: design/unicycle_dynamics_eval_unit.sv
// Channel   Modport       Role
// query     ude_in_if     sink: heading, speed, turn rate and the two controls
// result    ude_out_if    source: state derivative, heading Jacobian terms, cos, sin
//
// Registered stages, in order: the CORDIC rotations (min(CORDIC_STEPS, 30) of them),
// trig rounding, the multipliers, and rounding and saturation.
// A new item is taken every cycle unless the pipeline is full and result is stalled;
// every stage has its own valid bit. Reset clears only the valid bits. If result
// stalls, a full stage holds while all later stages are full; empty ones still fill.
module unicycle_dynamics_eval_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int CORDIC_STEPS = 14
) (
	input  logic clk,
	input  logic arst_n,
	ude_in_if.sink query,
	ude_out_if.source result
);
	import ude_pkg::*;

	localparam int STEPS = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;
	localparam int SIDE_W = 4 * DATA_WIDTH;

	logic cord_valid [STEPS+1];
	logic cord_ready [STEPS+1];
	cordic_t cord_data [STEPS+1];
	logic [SIDE_W-1:0] cord_side [STEPS+1];

	logic [ANGLE_W-1:0] ang;
	logic flip;

	assign ang = ANGLE_W'(unsigned'(query.heading)) << (ANGLE_W - DATA_WIDTH);
	assign flip = ang[ANGLE_W-1] ^ ang[ANGLE_W-2];

	assign cord_valid[0] = query.valid;
	assign query.ready = cord_ready[0];
	assign cord_data[0].x = CORDIC_GAIN;
	assign cord_data[0].y = '0;
	assign cord_data[0].z = signed'({ang[ANGLE_W-1] ^ flip, ang[ANGLE_W-2:0]});
	assign cord_data[0].flip = flip;
	assign cord_side[0] = {query.turn_accel, query.accel, query.turn_rate, query.speed};

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		ude_cordic_step #(
			.STEP(i),
			.SIDE_W(SIDE_W)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(cord_valid[i]),
			.in_ready(cord_ready[i]),
			.in_data(cord_data[i]),
			.in_side(cord_side[i]),
			.out_valid(cord_valid[i+1]),
			.out_ready(cord_ready[i+1]),
			.out_data(cord_data[i+1]),
			.out_side(cord_side[i+1])
		);
	end

	logic valid_s2;
	logic signed [TRIG_W-1:0] cos_s2;
	logic signed [TRIG_W-1:0] sin_s2;
	logic [SIDE_W-1:0] side_s2;
	logic prod_ready;

	assign cord_ready[STEPS] = !valid_s2 || prod_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (cord_ready[STEPS]) begin
			valid_s2 <= cord_valid[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (cord_ready[STEPS] && cord_valid[STEPS]) begin
			cos_s2 <= trig_round(cord_data[STEPS].x, cord_data[STEPS].flip);
			sin_s2 <= trig_round(cord_data[STEPS].y, cord_data[STEPS].flip);
			side_s2 <= cord_side[STEPS];
		end
	end

	ude_product #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_product (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s2),
		.in_ready(prod_ready),
		.cos_in(cos_s2),
		.sin_in(sin_s2),
		.speed(side_s2[DATA_WIDTH-1:0]),
		.turn_rate(side_s2[2*DATA_WIDTH-1:DATA_WIDTH]),
		.accel(side_s2[3*DATA_WIDTH-1:2*DATA_WIDTH]),
		.turn_accel(side_s2[4*DATA_WIDTH-1:3*DATA_WIDTH]),
		.result(result)
	);
endmodule
